// ===== src/rqi_pkg.sv =====
// ----------------------------------------------------------------------------
// rqi_pkg: shared types and constants for the ray / quad UV intersector
// Field widths, internal word sizes, register indexes and beat structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rqi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QBITS         = 16;

  localparam int IW            = 32;
  localparam int ROT_BITS      = 18;
  localparam int SIZE_BITS     = 31;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 31;
  localparam int UVW           = 17;

  localparam int BW    = 22;
  localparam int WW    = IW + 1;
  localparam int DW    = 56;
  localparam int SPLIT = 28;
  localparam int NW    = 112;
  localparam int TW    = NW + 1;
  localparam int PW    = 88;
  localparam int RW    = 106;
  localparam int QB    = 18;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_W  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_X  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_Y  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_Z  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUAD_W = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUAD_H = 3'd5;

  localparam logic [UVW-1:0] UV_HALF = 17'd32768;

  typedef struct packed {
    logic signed [IW-1:0] origin_x;
    logic signed [IW-1:0] origin_y;
    logic signed [IW-1:0] origin_z;
    logic signed [IW-1:0] dir_x;
    logic signed [IW-1:0] dir_y;
    logic signed [IW-1:0] dir_z;
    logic signed [IW-1:0] center_x;
    logic signed [IW-1:0] center_y;
    logic signed [IW-1:0] center_z;
  } rqi_in_t;

  typedef struct packed {
    logic           hit;
    logic [UVW-1:0] tex_u;
    logic [UVW-1:0] tex_v;
  } rqi_out_t;

  typedef struct packed {
    logic signed [ROT_BITS-1:0] rot_w;
    logic signed [ROT_BITS-1:0] rot_x;
    logic signed [ROT_BITS-1:0] rot_y;
    logic signed [ROT_BITS-1:0] rot_z;
    logic [SIZE_BITS-1:0]       quad_width;
    logic [SIZE_BITS-1:0]       quad_height;
  } rqi_cfg_t;

  typedef struct packed {
    logic signed [BW-1:0] r_x;
    logic signed [BW-1:0] r_y;
    logic signed [BW-1:0] r_z;
    logic signed [BW-1:0] u_x;
    logic signed [BW-1:0] u_y;
    logic signed [BW-1:0] u_z;
    logic signed [BW-1:0] n_x;
    logic signed [BW-1:0] n_y;
    logic signed [BW-1:0] n_z;
  } rqi_basis_t;

  typedef struct packed {
    logic signed [DW-1:0] den;
    logic signed [DW-1:0] num;
    logic signed [DW-1:0] dr;
    logic signed [DW-1:0] du;
    logic signed [DW-1:0] wr;
    logic signed [DW-1:0] wu;
  } rqi_dot_t;

  typedef struct packed {
    logic signed [NW-1:0] n;
    logic [PW-1:0]        d;
  } rqi_lane_t;

  typedef struct packed {
    logic      miss;
    logic      den_neg;
    rqi_lane_t u;
    rqi_lane_t v;
  } rqi_cross_t;

  typedef struct packed {
    logic          out;
    logic          flip;
    logic [RW-1:0] rem;
    logic [PW:0]   den2;
    logic [QB-1:0] q;
  } rqi_div_lane_t;

endpackage

`default_nettype wire

// ===== src/rqi_basis.sv =====
// ----------------------------------------------------------------------------
// rqi_basis: quaternion to right / up / normal basis
// Two register stages: component products, then rounded Q.16 basis vectors.
// ----------------------------------------------------------------------------
`default_nettype none

module rqi_basis (
  input  logic                clk,
  input  rqi_pkg::rqi_cfg_t   cfg,
  output rqi_pkg::rqi_basis_t basis
);
  import rqi_pkg::*;

  localparam int PRW  = 2 * ROT_BITS;
  localparam int RAWW = 40;
  localparam logic signed [RAWW-1:0] ONE_Q  = 40'sh01_0000_0000;
  localparam logic signed [RAWW-1:0] HALF_Q = 40'sh00_0000_8000;

  logic signed [PRW-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  rqi_basis_t basis_r, basis_nxt;

  function automatic logic signed [BW-1:0] rnd(input logic signed [RAWW-1:0] v);
    logic signed [RAWW-1:0] t;
    t = (v + HALF_Q) >>> QBITS;
    return t[BW-1:0];
  endfunction

  function automatic logic signed [RAWW-1:0] two_sum(input logic signed [PRW-1:0] a,
                                                     input logic signed [PRW-1:0] b);
    return (RAWW'(a) + RAWW'(b)) <<< 1;
  endfunction

  function automatic logic signed [RAWW-1:0] two_dif(input logic signed [PRW-1:0] a,
                                                     input logic signed [PRW-1:0] b);
    return (RAWW'(a) - RAWW'(b)) <<< 1;
  endfunction

  always_ff @(posedge clk) begin
    xx_r <= cfg.rot_x * cfg.rot_x;
    yy_r <= cfg.rot_y * cfg.rot_y;
    zz_r <= cfg.rot_z * cfg.rot_z;
    xy_r <= cfg.rot_x * cfg.rot_y;
    xz_r <= cfg.rot_x * cfg.rot_z;
    yz_r <= cfg.rot_y * cfg.rot_z;
    wx_r <= cfg.rot_w * cfg.rot_x;
    wy_r <= cfg.rot_w * cfg.rot_y;
    wz_r <= cfg.rot_w * cfg.rot_z;
  end

  always_comb begin
    basis_nxt.r_x = rnd(ONE_Q - two_sum(yy_r, zz_r));
    basis_nxt.r_y = rnd(two_sum(xy_r, wz_r));
    basis_nxt.r_z = rnd(two_dif(xz_r, wy_r));
    basis_nxt.u_x = rnd(two_dif(xy_r, wz_r));
    basis_nxt.u_y = rnd(ONE_Q - two_sum(xx_r, zz_r));
    basis_nxt.u_z = rnd(two_sum(yz_r, wx_r));
    basis_nxt.n_x = rnd(two_sum(xz_r, wy_r));
    basis_nxt.n_y = rnd(two_dif(yz_r, wx_r));
    basis_nxt.n_z = rnd(ONE_Q - two_sum(xx_r, yy_r));
  end

  always_ff @(posedge clk) begin
    basis_r <= basis_nxt;
  end

  assign basis = basis_r;

endmodule

`default_nettype wire

// ===== src/rqi_front.sv =====
// ----------------------------------------------------------------------------
// rqi_front: ray input stages and dot products
// Register beat, form centre minus origin, multiply by basis, sum the dots.
// ----------------------------------------------------------------------------
`default_nettype none

module rqi_front (
  input  logic                clk,
  input  logic                rst_n,
  input  rqi_pkg::rqi_basis_t basis,
  input  logic                up_valid,
  output logic                up_ready,
  input  rqi_pkg::rqi_in_t    up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output rqi_pkg::rqi_dot_t   dn_data
);
  import rqi_pkg::*;

  logic [3:0] v_r, v_nxt;
  wire  [3:0] en;

  rqi_in_t              s1_r;
  logic signed [IW-1:0] d_nxt [3];
  logic signed [IW-1:0] d_r   [3];
  logic signed [WW-1:0] w_nxt [3];
  logic signed [WW-1:0] w_r   [3];
  logic signed [BW-1:0] bn [3];
  logic signed [BW-1:0] br [3];
  logic signed [BW-1:0] bu [3];
  logic signed [DW-1:0] pdn_nxt [3], pdr_nxt [3], pdu_nxt [3];
  logic signed [DW-1:0] pwn_nxt [3], pwr_nxt [3], pwu_nxt [3];
  logic signed [DW-1:0] pdn_r [3], pdr_r [3], pdu_r [3];
  logic signed [DW-1:0] pwn_r [3], pwr_r [3], pwu_r [3];
  rqi_dot_t             dot_r, dot_nxt;

  assign en[3]    = !v_r[3] || dn_ready;
  assign en[2]    = !v_r[2] || en[3];
  assign en[1]    = !v_r[1] || en[2];
  assign en[0]    = !v_r[0] || en[1];
  assign up_ready = en[0];
  assign dn_valid = v_r[3];
  assign dn_data  = dot_r;

  always_comb begin
    v_nxt = v_r;
    if (en[0]) v_nxt[0] = up_valid;
    if (en[1]) v_nxt[1] = v_r[0];
    if (en[2]) v_nxt[2] = v_r[1];
    if (en[3]) v_nxt[3] = v_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    d_nxt[0] = s1_r.dir_x;
    d_nxt[1] = s1_r.dir_y;
    d_nxt[2] = s1_r.dir_z;
    w_nxt[0] = WW'(s1_r.center_x) - WW'(s1_r.origin_x);
    w_nxt[1] = WW'(s1_r.center_y) - WW'(s1_r.origin_y);
    w_nxt[2] = WW'(s1_r.center_z) - WW'(s1_r.origin_z);
    bn[0] = basis.n_x; bn[1] = basis.n_y; bn[2] = basis.n_z;
    br[0] = basis.r_x; br[1] = basis.r_y; br[2] = basis.r_z;
    bu[0] = basis.u_x; bu[1] = basis.u_y; bu[2] = basis.u_z;
    for (int i = 0; i < 3; i++) begin
      pdn_nxt[i] = d_r[i] * bn[i];
      pdr_nxt[i] = d_r[i] * br[i];
      pdu_nxt[i] = d_r[i] * bu[i];
      pwn_nxt[i] = w_r[i] * bn[i];
      pwr_nxt[i] = w_r[i] * br[i];
      pwu_nxt[i] = w_r[i] * bu[i];
    end
    dot_nxt.den = pdn_r[0] + pdn_r[1] + pdn_r[2];
    dot_nxt.num = pwn_r[0] + pwn_r[1] + pwn_r[2];
    dot_nxt.dr  = pdr_r[0] + pdr_r[1] + pdr_r[2];
    dot_nxt.du  = pdu_r[0] + pdu_r[1] + pdu_r[2];
    dot_nxt.wr  = pwr_r[0] + pwr_r[1] + pwr_r[2];
    dot_nxt.wu  = pwu_r[0] + pwu_r[1] + pwu_r[2];
  end

  always_ff @(posedge clk) begin
    if (en[0]) s1_r <= up_data;
    if (en[1]) begin
      d_r <= d_nxt;
      w_r <= w_nxt;
    end
    if (en[2]) begin
      pdn_r <= pdn_nxt;
      pdr_r <= pdr_nxt;
      pdu_r <= pdu_nxt;
      pwn_r <= pwn_nxt;
      pwr_r <= pwr_nxt;
      pwu_r <= pwu_nxt;
    end
    if (en[3]) dot_r <= dot_nxt;
  end

endmodule

`default_nettype wire

// ===== src/rqi_cross.sv =====
// ----------------------------------------------------------------------------
// rqi_cross: early miss tests and wide cross products
// Split 56x56 products into partials, sum them, form N and the size scale.
// ----------------------------------------------------------------------------
`default_nettype none

module rqi_cross #(
  parameter int FRAC_BITS = rqi_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [rqi_pkg::SIZE_BITS-1:0]       quad_width,
  input  logic [rqi_pkg::SIZE_BITS-1:0]       quad_height,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  rqi_pkg::rqi_dot_t                   up_data,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output rqi_pkg::rqi_cross_t                 dn_data
);
  import rqi_pkg::*;

  localparam logic [63:0] PAR_EPS =
    ((64'd1 << (FRAC_BITS + 16)) + 64'd500000) / 64'd1000000;
  localparam int HW  = DW - SPLIT;
  localparam int SPW = HW + SIZE_BITS;

  typedef struct packed {
    logic        [2*SPLIT-1:0] ll;
    logic signed [2*SPLIT:0]   lh;
    logic signed [2*SPLIT:0]   hl;
    logic signed [2*HW-1:0]    hh;
  } pp_t;

  function automatic pp_t ppmul(input logic signed [DW-1:0] a,
                                input logic signed [DW-1:0] b);
    pp_t                  r;
    logic [SPLIT-1:0]     al, bl;
    logic signed [HW-1:0] ah, bh;
    al   = a[SPLIT-1:0];
    bl   = b[SPLIT-1:0];
    ah   = a[DW-1:SPLIT];
    bh   = b[DW-1:SPLIT];
    r.ll = al * bl;
    r.lh = $signed({1'b0, al}) * bh;
    r.hl = ah * $signed({1'b0, bl});
    r.hh = ah * bh;
    return r;
  endfunction

  function automatic logic signed [NW-1:0] ppsum(input pp_t p);
    logic [NW-1:0] s;
    s = (NW'(p.hh) << (2 * SPLIT)) + ((NW'(p.lh) + NW'(p.hl)) << SPLIT) + NW'(p.ll);
    return s;
  endfunction

  logic [2:0] v_r, v_nxt;
  wire  [2:0] en;

  logic [DW-1:0]        den_mag;
  logic [SIZE_BITS-1:0] w_eff, h_eff;
  logic                 miss1_nxt, miss1_r, dneg1_r, miss2_r, dneg2_r;
  pp_t                  pa_u_r, pb_u_r, pa_v_r, pb_v_r;
  logic [SPW-1:0]       sl_u_r, sh_u_r, sl_v_r, sh_v_r;
  logic signed [NW-1:0] a_u_r, b_u_r, a_v_r, b_v_r;
  logic [PW-1:0]        du_r, dv_r;
  rqi_cross_t           out_r, out_nxt;

  assign en[2]    = !v_r[2] || dn_ready;
  assign en[1]    = !v_r[1] || en[2];
  assign en[0]    = !v_r[0] || en[1];
  assign up_ready = en[0];
  assign dn_valid = v_r[2];
  assign dn_data  = out_r;

  always_comb begin
    v_nxt = v_r;
    if (en[0]) v_nxt[0] = up_valid;
    if (en[1]) v_nxt[1] = v_r[0];
    if (en[2]) v_nxt[2] = v_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    den_mag   = up_data.den[DW-1] ? DW'(-up_data.den) : DW'(up_data.den);
    miss1_nxt = (den_mag < PAR_EPS[DW-1:0]) ||
                ((up_data.num != '0) && (up_data.num[DW-1] != up_data.den[DW-1]));
    w_eff     = (quad_width == '0) ? SIZE_BITS'(1) : quad_width;
    h_eff     = (quad_height == '0) ? SIZE_BITS'(1) : quad_height;
    out_nxt.miss    = miss2_r;
    out_nxt.den_neg = dneg2_r;
    out_nxt.u.n     = a_u_r - b_u_r;
    out_nxt.u.d     = du_r;
    out_nxt.v.n     = a_v_r - b_v_r;
    out_nxt.v.d     = dv_r;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      miss1_r <= miss1_nxt;
      dneg1_r <= up_data.den[DW-1];
      pa_u_r  <= ppmul(up_data.num, up_data.dr);
      pb_u_r  <= ppmul(up_data.den, up_data.wr);
      pa_v_r  <= ppmul(up_data.num, up_data.du);
      pb_v_r  <= ppmul(up_data.den, up_data.wu);
      sl_u_r  <= den_mag[SPLIT-1:0] * w_eff;
      sh_u_r  <= den_mag[DW-1:SPLIT] * w_eff;
      sl_v_r  <= den_mag[SPLIT-1:0] * h_eff;
      sh_v_r  <= den_mag[DW-1:SPLIT] * h_eff;
    end
    if (en[1]) begin
      miss2_r <= miss1_r;
      dneg2_r <= dneg1_r;
      a_u_r   <= ppsum(pa_u_r);
      b_u_r   <= ppsum(pb_u_r);
      a_v_r   <= ppsum(pa_v_r);
      b_v_r   <= ppsum(pb_v_r);
      du_r    <= PW'(sl_u_r) + (PW'(sh_u_r) << SPLIT);
      dv_r    <= PW'(sl_v_r) + (PW'(sh_v_r) << SPLIT);
    end
    if (en[2]) out_r <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== src/rqi_div.sv =====
// ----------------------------------------------------------------------------
// rqi_div: edge test and pipelined rounding divider
// Prep stage, one restoring quotient bit per stage, then UV output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rqi_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  rqi_pkg::rqi_cross_t up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output rqi_pkg::rqi_out_t   dn_data
);
  import rqi_pkg::*;

  localparam int NS = QB + 2;

  function automatic rqi_div_lane_t prep(input rqi_lane_t ln, input logic den_neg);
    rqi_div_lane_t r;
    logic          nneg;
    logic [NW-1:0] an;
    logic [TW-1:0] twice, lim;
    nneg   = ln.n[NW-1];
    an     = nneg ? NW'(-ln.n) : NW'(ln.n);
    twice  = {an, 1'b0};
    lim    = TW'(ln.d) << QBITS;
    r.out  = twice > lim;
    r.flip = nneg ^ den_neg;
    r.rem  = RW'(twice + TW'(ln.d));
    r.den2 = {ln.d, 1'b0};
    r.q    = '0;
    return r;
  endfunction

  function automatic rqi_div_lane_t step(input rqi_div_lane_t ln, input int b);
    rqi_div_lane_t r;
    logic [RW-1:0] t;
    r = ln;
    t = RW'(ln.den2) << b;
    if (ln.rem >= t) begin
      r.rem = ln.rem - t;
      r.q   = ln.q | (QB'(1) << b);
    end
    return r;
  endfunction

  function automatic logic [UVW-1:0] coord(input rqi_div_lane_t ln);
    logic [QB-1:0] q;
    q = (ln.q > QB'(UV_HALF)) ? QB'(UV_HALF) : ln.q;
    return ln.flip ? UV_HALF - UVW'(q) : UV_HALF + UVW'(q);
  endfunction

  logic [NS-1:0] v_r, v_nxt;
  wire  [NS-1:0] en;

  rqi_div_lane_t lu_nxt [QB+1];
  rqi_div_lane_t lv_nxt [QB+1];
  rqi_div_lane_t lu_r   [QB+1];
  rqi_div_lane_t lv_r   [QB+1];
  logic          miss_r [QB+1];
  logic          miss_all;
  rqi_out_t      out_r, out_nxt;

  assign en[NS-1] = !v_r[NS-1] || dn_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign up_ready = en[0];
  assign dn_valid = v_r[NS-1];
  assign dn_data  = out_r;

  always_comb begin
    v_nxt = v_r;
    if (en[0]) v_nxt[0] = up_valid;
    for (int k = 1; k < NS; k++) begin
      if (en[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    lu_nxt[0] = prep(up_data.u, up_data.den_neg);
    lv_nxt[0] = prep(up_data.v, up_data.den_neg);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lu_r[0]   <= lu_nxt[0];
      lv_r[0]   <= lv_nxt[0];
      miss_r[0] <= up_data.miss;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    always_comb begin
      lu_nxt[k] = step(lu_r[k-1], QB - k);
      lv_nxt[k] = step(lv_r[k-1], QB - k);
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        lu_r[k]   <= lu_nxt[k];
        lv_r[k]   <= lv_nxt[k];
        miss_r[k] <= miss_r[k-1];
      end
    end
  end

  always_comb begin
    miss_all      = miss_r[QB] || lu_r[QB].out || lv_r[QB].out;
    out_nxt.hit   = !miss_all;
    out_nxt.tex_u = miss_all ? '0 : coord(lu_r[QB]);
    out_nxt.tex_v = miss_all ? '0 : coord(lv_r[QB]);
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) out_r <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== src/ray_quad_intersect_uv_core.sv =====
// ----------------------------------------------------------------------------
// ray_quad_intersect_uv_core: ray / oriented quad intersection with UV output
//
// Input channel (in_valid / in_ready / in_data) takes one ray per beat: origin,
// direction and quad centre, signed Q16.16. Output channel (out_valid /
// out_ready / out_data) returns one beat per ray: hit flag and Q1.16 UV, with
// UV zero on a miss. The cfg port writes the orientation quaternion and quad
// size one field per write; write only while no ray is in flight.
//
// Throughput is one ray per cycle while out_ready is high. A ray passes through
// 4 front stages (register, subtract, multiply, sum), 3 cross-product stages,
// a prep stage, 18 divider stages (one quotient bit each) and the output
// register. Every stage holds its own valid bit, so a stalled receiver backs
// the pipe up stage by stage; in_ready drops only when every stage is full.
// Bubbles are squeezed out while out_ready is low.
//
// Synchronous active-low reset empties the pipe and loads identity rotation
// and a 1.0 x 1.0 quad.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_quad_intersect_uv_core #(
  parameter int FRAC_BITS = rqi_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rqi_pkg::rqi_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rqi_pkg::rqi_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [rqi_pkg::CFG_IDX_BITS-1:0]   cfg_addr,
  input  logic [rqi_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import rqi_pkg::*;

  rqi_cfg_t   cfg_r;
  rqi_basis_t basis;
  rqi_dot_t   dot_data;
  rqi_cross_t cross_data;
  logic       dot_valid, dot_ready, cross_valid, cross_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot_w       <= 18'sd65536;
      cfg_r.rot_x       <= '0;
      cfg_r.rot_y       <= '0;
      cfg_r.rot_z       <= '0;
      cfg_r.quad_width  <= SIZE_BITS'(64'd1 << FRAC_BITS);
      cfg_r.quad_height <= SIZE_BITS'(64'd1 << FRAC_BITS);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ROT_W:  cfg_r.rot_w       <= cfg_wdata[ROT_BITS-1:0];
        CFG_ROT_X:  cfg_r.rot_x       <= cfg_wdata[ROT_BITS-1:0];
        CFG_ROT_Y:  cfg_r.rot_y       <= cfg_wdata[ROT_BITS-1:0];
        CFG_ROT_Z:  cfg_r.rot_z       <= cfg_wdata[ROT_BITS-1:0];
        CFG_QUAD_W: cfg_r.quad_width  <= cfg_wdata[SIZE_BITS-1:0];
        CFG_QUAD_H: cfg_r.quad_height <= cfg_wdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  rqi_basis u_basis (
    .clk   (clk),
    .cfg   (cfg_r),
    .basis (basis)
  );

  rqi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .basis    (basis),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (dot_valid),
    .dn_ready (dot_ready),
    .dn_data  (dot_data)
  );

  rqi_cross #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cross (
    .clk         (clk),
    .rst_n       (rst_n),
    .quad_width  (cfg_r.quad_width),
    .quad_height (cfg_r.quad_height),
    .up_valid    (dot_valid),
    .up_ready    (dot_ready),
    .up_data     (dot_data),
    .dn_valid    (cross_valid),
    .dn_ready    (cross_ready),
    .dn_data     (cross_data)
  );

  rqi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cross_valid),
    .up_ready (cross_ready),
    .up_data  (cross_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.tex_u == '0 && out_data.tex_v == '0)
    else $error("miss beat carries nonzero UV");

  a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.tex_u <= 17'd65536 && out_data.tex_v <= 17'd65536)
    else $error("hit beat UV above one");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off while output not stalled");
`endif

endmodule

`default_nettype wire

// ===== bench/ray_quad_intersect_uv_core_tb.sv =====
// ----------------------------------------------------------------------------
// ray_quad_intersect_uv_core_tb: self-checking bench for the ray / quad core
// Drives a directed table of rays, then random aimed and noise rays under a
// series of orientations and quad sizes, with random idling on both channels
// and one long receiver hold-off. Each output beat is checked against its
// directed expectation or a local fixed-point intersection predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_quad_intersect_uv_core_tb;
  import rqi_pkg::*;

  localparam longint PAR_EPS = ((64'd1 << 32) + 64'd500000) / 64'd1000000;
  localparam logic signed [IW-1:0] ONE = 32'sh0001_0000;
  localparam logic signed [IW-1:0] HALF = 32'sh0000_8000;
  localparam int LATENCY = 26;

  typedef struct {
    rqi_in_t  beat;
    bit       typed;
    rqi_out_t want;
  } ray_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rqi_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rqi_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  logic signed [ROT_BITS-1:0] m_rot_w = 18'sd65536;
  logic signed [ROT_BITS-1:0] m_rot_x = '0;
  logic signed [ROT_BITS-1:0] m_rot_y = '0;
  logic signed [ROT_BITS-1:0] m_rot_z = '0;
  logic [SIZE_BITS-1:0] m_width = 31'd65536;
  logic [SIZE_BITS-1:0] m_height = 31'd65536;
  longint basis_r[3];
  longint basis_u[3];
  longint basis_n[3];

  ray_row_t ray_q[$];
  rqi_out_t uv_expect_q[$];
  ray_row_t cur_row;
  bit beat_taken = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int err_cnt = 0;

  ray_quad_intersect_uv_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("ray_quad_intersect_uv_core_tb: done, errors");
    $finish;
  end

  function automatic void calc_basis();
    longint qw, qx, qy, qz, one32, rnd;
    longint rr[3], ru[3], rn[3];
    qw = longint'(m_rot_w);
    qx = longint'(m_rot_x);
    qy = longint'(m_rot_y);
    qz = longint'(m_rot_z);
    one32 = 64'sd1 <<< 32;
    rnd = 64'sd1 <<< 15;
    rr[0] = one32 - 2 * (qy * qy + qz * qz);
    rr[1] = 2 * (qx * qy + qw * qz);
    rr[2] = 2 * (qx * qz - qw * qy);
    ru[0] = 2 * (qx * qy - qw * qz);
    ru[1] = one32 - 2 * (qx * qx + qz * qz);
    ru[2] = 2 * (qy * qz + qw * qx);
    rn[0] = 2 * (qx * qz + qw * qy);
    rn[1] = 2 * (qy * qz - qw * qx);
    rn[2] = one32 - 2 * (qx * qx + qy * qy);
    for (int i = 0; i < 3; i++) begin
      basis_r[i] = (rr[i] + rnd) >>> 16;
      basis_u[i] = (ru[i] + rnd) >>> 16;
      basis_n[i] = (rn[i] + rnd) >>> 16;
    end
  endfunction

  // bit 17 set when inside the quad, low 17 bits the coordinate
  function automatic logic [17:0] map_uv(logic signed [127:0] n, bit den_neg,
                                         logic [127:0] den_mag, logic [SIZE_BITS-1:0] size);
    logic [127:0] an, dd, q;
    bit nneg;
    nneg = n[127];
    an = nneg ? -n : n;
    dd = den_mag * ((size == 0) ? 128'd1 : 128'(size));
    if ((an << 1) > (dd << 16)) return '0;
    q = ((an << 1) + dd) / (dd << 1);
    if (q > 128'd32768) q = 128'd32768;
    return {1'b1, (nneg != den_neg) ? 17'(32768 - q) : 17'(32768 + q)};
  endfunction

  function automatic rqi_out_t predict_uv(rqi_in_t p);
    longint o[3], d[3], w[3];
    longint den, num, dr, du, wr, wu;
    logic signed [127:0] nu, nv;
    logic [127:0] dmag;
    logic [17:0] cu, cv;
    rqi_out_t r;
    r = '0;
    o[0] = longint'(p.origin_x); o[1] = longint'(p.origin_y); o[2] = longint'(p.origin_z);
    d[0] = longint'(p.dir_x); d[1] = longint'(p.dir_y); d[2] = longint'(p.dir_z);
    w[0] = longint'(p.center_x) - o[0];
    w[1] = longint'(p.center_y) - o[1];
    w[2] = longint'(p.center_z) - o[2];
    den = d[0] * basis_n[0] + d[1] * basis_n[1] + d[2] * basis_n[2];
    num = w[0] * basis_n[0] + w[1] * basis_n[1] + w[2] * basis_n[2];
    dr = d[0] * basis_r[0] + d[1] * basis_r[1] + d[2] * basis_r[2];
    du = d[0] * basis_u[0] + d[1] * basis_u[1] + d[2] * basis_u[2];
    wr = w[0] * basis_r[0] + w[1] * basis_r[1] + w[2] * basis_r[2];
    wu = w[0] * basis_u[0] + w[1] * basis_u[1] + w[2] * basis_u[2];
    dmag = (den < 0) ? 128'(-den) : 128'(den);
    if (dmag < 128'(PAR_EPS)) return r;
    if (num != 0 && ((num < 0) != (den < 0))) return r;
    nu = 128'(num) * 128'(dr) - 128'(den) * 128'(wr);
    nv = 128'(num) * 128'(du) - 128'(den) * 128'(wu);
    cu = map_uv(nu, den < 0, dmag, m_width);
    cv = map_uv(nv, den < 0, dmag, m_height);
    if (!cu[17] || !cv[17]) return r;
    r.hit = 1'b1;
    r.tex_u = cu[16:0];
    r.tex_v = cv[16:0];
    return r;
  endfunction

  function automatic rqi_in_t make_ray(logic signed [IW-1:0] ox, oy, oz, dx, dy, dz,
                                       cx, cy, cz);
    rqi_in_t b;
    b.origin_x = ox; b.origin_y = oy; b.origin_z = oz;
    b.dir_x = dx; b.dir_y = dy; b.dir_z = dz;
    b.center_x = cx; b.center_y = cy; b.center_z = cz;
    return b;
  endfunction

  function automatic longint srand_span(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  function automatic ray_row_t aimed_ray(bit flip);
    ray_row_t row;
    longint c[3], dv[3], pt[3], org[3];
    longint sw, sh, a, b, k;
    sw = ((m_width == 0) ? 1 : longint'(m_width)) / 2;
    sh = ((m_height == 0) ? 1 : longint'(m_height)) / 2;
    if (sw > (1 << 22)) sw = 1 << 22;
    if (sh > (1 << 22)) sh = 1 << 22;
    a = ($urandom_range(0, 7) == 0) ? sw : srand_span(sw);
    b = ($urandom_range(0, 7) == 0) ? -sh : srand_span(sh);
    k = $urandom_range(1, 4);
    for (int i = 0; i < 3; i++) begin
      c[i] = srand_span(100 * 65536);
      dv[i] = srand_span(32768) + 2 * basis_n[i];
      if (flip) dv[i] = -dv[i];
      pt[i] = c[i] + ((a * basis_r[i] + b * basis_u[i]) >>> 16);
      org[i] = flip ? pt[i] + k * dv[i] : pt[i] - k * dv[i];
    end
    row.beat = make_ray(32'(org[0]), 32'(org[1]), 32'(org[2]),
                        32'(dv[0]), 32'(dv[1]), 32'(dv[2]),
                        32'(c[0]), 32'(c[1]), 32'(c[2]));
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch %s: got %0d, want %0d", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROT_W: m_rot_w = val[ROT_BITS-1:0];
      CFG_ROT_X: m_rot_x = val[ROT_BITS-1:0];
      CFG_ROT_Y: m_rot_y = val[ROT_BITS-1:0];
      CFG_ROT_Z: m_rot_z = val[ROT_BITS-1:0];
      CFG_QUAD_W: m_width = val;
      CFG_QUAD_H: m_height = val;
      default: ;
    endcase
    calc_basis();
  endtask

  task automatic set_quad(int qw, int qx, int qy, int qz, int wid, int hgt);
    write_reg(CFG_ROT_W, 31'(qw));
    write_reg(CFG_ROT_X, 31'(qx));
    write_reg(CFG_ROT_Y, 31'(qy));
    write_reg(CFG_ROT_Z, 31'(qz));
    write_reg(CFG_QUAD_W, 31'(wid));
    write_reg(CFG_QUAD_H, 31'(hgt));
    write_reg(3'd6 + 3'($urandom_range(0, 1)), 31'($urandom));
  endtask

  task automatic drain();
    wait (ray_q.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (uv_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int n, int spct, int rpct, int hold);
    ray_row_t row;
    send_idle_pct = spct;
    recv_idle_pct = rpct;
    hold_cycles = hold;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          row.beat = rqi_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom});
          row.typed = 1'b0;
          row.want = '0;
        end
        2: row = aimed_ray(1'b1);
        default: row = aimed_ray(1'b0);
      endcase
      ray_q.push_back(row);
    end
    drain();
  endtask

  always @(posedge clk) begin
    beat_taken = 1'b0;
    if (rst_n && in_valid && in_ready) begin
      uv_expect_q.push_back(cur_row.typed ? cur_row.want : predict_uv(cur_row.beat));
      beat_taken = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (uv_expect_q.size() == 0) begin
        report_mismatch("unexpected beat, hit", longint'(out_data.hit), -1);
      end else begin
        rqi_out_t want;
        want = uv_expect_q.pop_front();
        if (out_data.hit !== want.hit)
          report_mismatch("hit", longint'(out_data.hit), longint'(want.hit));
        if (out_data.tex_u !== want.tex_u)
          report_mismatch("tex_u", longint'(out_data.tex_u), longint'(want.tex_u));
        if (out_data.tex_v !== want.tex_v)
          report_mismatch("tex_v", longint'(out_data.tex_v), longint'(want.tex_v));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      if (ray_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_row = ray_q.pop_front();
        in_data <= cur_row.beat;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    ray_row_t row;
    calc_basis();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rays under the reset orientation and unit quad
    row.typed = 1'b1;
    row.want = '{hit: 1'b1, tex_u: UV_HALF, tex_v: UV_HALF};
    row.beat = make_ray(0, 0, -ONE, 0, 0, ONE, 0, 0, 0);
    ray_q.push_back(row);
    row.beat = make_ray(0, 0, 0, 0, 0, ONE, 0, 0, 0);
    ray_q.push_back(row);
    row.want = '0;
    row.beat = make_ray(0, 0, ONE, 0, 0, ONE, 0, 0, 0);
    ray_q.push_back(row);
    row.beat = make_ray(0, 0, -ONE, 0, 0, 0, 0, 0, 0);
    ray_q.push_back(row);
    row.beat = make_ray(0, 0, -ONE, ONE, 0, 0, 0, 0, 0);
    ray_q.push_back(row);
    row.beat = make_ray(ONE - HALF / 2, 0, -ONE, 0, 0, ONE, 0, 0, 0);
    ray_q.push_back(row);
    row.beat = '0;
    ray_q.push_back(row);
    row.typed = 1'b0;
    row.beat = make_ray(HALF, 0, -ONE, 0, 0, ONE, 0, 0, 0);
    ray_q.push_back(row);
    row.beat = make_ray(-HALF, 0, -ONE, 0, 0, ONE, 0, 0, 0);
    ray_q.push_back(row);
    row.beat = make_ray(0, HALF, -ONE, 0, 0, ONE, 0, 0, 0);
    ray_q.push_back(row);
    row.beat = make_ray(0, -HALF, -ONE, 0, 0, ONE, 0, 0, 0);
    ray_q.push_back(row);
    row.beat = make_ray(-HALF / 2, HALF / 4, -ONE, 0, 0, 1, 0, 0, 0);
    ray_q.push_back(row);
    row.beat = make_ray(HALF / 3, -HALF / 5, -3 * ONE, HALF, 0, ONE, 0, 0, 0);
    ray_q.push_back(row);
    row.beat = rqi_in_t'({9{32'h7fff_ffff}});
    ray_q.push_back(row);
    row.beat = rqi_in_t'({9{32'h8000_0000}});
    ray_q.push_back(row);
    row.beat = rqi_in_t'({9{32'hffff_ffff}});
    ray_q.push_back(row);
    row.beat = make_ray(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                        32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                        32'sh7fff_ffff);
    ray_q.push_back(row);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();

    set_quad(65536, 0, 0, 0, 65536, 65536);
    run_phase(50, 37, 69, 0);
    set_quad(46341, 46341, 0, 0, 2 * 65536, 65536 / 2);
    run_phase(50, 37, 69, 0);
    set_quad(-65536, 0, 0, 0, 2147483647, 2147483647);
    run_phase(50, 69, 37, 0);
    set_quad(0, 65536, 0, 0, 1, 1);
    run_phase(40, 69, 37, 0);
    set_quad(0, 0, 0, 0, 0, 0);
    run_phase(30, 0, 0, 0);
    set_quad(-65536, -65536, -65536, -65536, 65536, 3 * 65536);
    run_phase(40, 0, 0, 300);
    set_quad(32768, 32768, 32768, 32768, 5 * 65536, 65536);
    run_phase(50, 0, 0, 0);
    for (int i = 0; i < 3; i++) begin
      set_quad(int'(srand_span(65536)), int'(srand_span(65536)), int'(srand_span(65536)),
               int'(srand_span(65536)), int'($urandom_range(1, 32'h7fff_ffff)),
               int'($urandom_range(1, 8 * 65536)));
      run_phase(45, 0, 0, 0);
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (err_cnt == 0 && uv_expect_q.size() == 0) begin
      $display("ray_quad_intersect_uv_core_tb: done, clean");
    end else begin
      $display("ray_quad_intersect_uv_core_tb: done, errors");
    end
    $finish;
  end

endmodule
